[rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, character codes and bracket-kind helpers for the bracket
// balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef logic [7:0] char_t;
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_BRACE   = 2'd0;
  localparam kind_t KIND_PAREN   = 2'd1;
  localparam kind_t KIND_BRACKET = 2'd2;
  localparam kind_t KIND_NONE    = 2'd3;

  localparam char_t CH_LBRACE    = 8'h7B;
  localparam char_t CH_LPAREN    = 8'h28;
  localparam char_t CH_LBRACKET  = 8'h5B;
  localparam char_t CH_RBRACE    = 8'h7D;
  localparam char_t CH_RPAREN    = 8'h29;
  localparam char_t CH_RBRACKET  = 8'h5D;
  localparam char_t CH_DQUOTE    = 8'h22;
  localparam char_t CH_SQUOTE    = 8'h27;
  localparam char_t CH_BACKSLASH = 8'h5C;

  // stack operation from the scanner to the stack unit
  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t kind;
  } stk_op_t;

  // stack status back to the scanner
  typedef struct packed {
    logic  empty;
    logic  full;
    kind_t top_kind;
  } stk_stat_t;

  function automatic kind_t opener_kind(input char_t c);
    kind_t k;
    case (c)
      CH_LBRACE:   k = KIND_BRACE;
      CH_LPAREN:   k = KIND_PAREN;
      CH_LBRACKET: k = KIND_BRACKET;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t closer_kind(input char_t c);
    kind_t k;
    case (c)
      CH_RBRACE:   k = KIND_BRACE;
      CH_RPAREN:   k = KIND_PAREN;
      CH_RBRACKET: k = KIND_BRACKET;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic char_t opener_char(input kind_t k);
    char_t c;
    case (k)
      KIND_BRACE:   c = CH_LBRACE;
      KIND_PAREN:   c = CH_LPAREN;
      KIND_BRACKET: c = CH_LBRACKET;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic char_t closer_char(input kind_t k);
    char_t c;
    case (k)
      KIND_BRACE:   c = CH_RBRACE;
      KIND_PAREN:   c = CH_RPAREN;
      KIND_BRACKET: c = CH_RBRACKET;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/bbc_ram.sv]
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bbc_stack.sv]
// ----------------------------------------------------------------------------
// bbc_stack
// Bracket-kind stack: top entry in a register, the rest in RAM. The entry
// just below the top is read every cycle so that a pop has the new top ready.
// ----------------------------------------------------------------------------
module bbc_stack #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bbc_pkg::stk_op_t                 op,
  output bbc_pkg::stk_stat_t               stat,
  output logic [$clog2(STACK_DEPTH+1)-1:0] depth
);

  import bbc_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [DW-1:0] depth_r, depth_nxt, rd_ptr;
  kind_t         top_r, top_nxt;
  kind_t         below;

  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (op.push) begin
      depth_nxt = depth_r + DW'(1);
      top_nxt   = op.kind;
    end else if (op.pop) begin
      depth_nxt = depth_r - DW'(1);
      top_nxt   = below;
    end
  end

  // entry below the new top; meaningless (and unused) when depth < 2
  assign rd_ptr = depth_nxt - DW'(2);

  bbc_ram #(
    .WIDTH ($bits(kind_t)),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (op.push),
    .wr_addr (depth_r[AW-1:0]),
    .wr_data (op.kind),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (below)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
    top_r <= top_nxt;
  end

  assign stat.empty    = (depth_r == '0);
  assign stat.full     = (depth_r == DW'(STACK_DEPTH));
  assign stat.top_kind = top_r;
  assign depth         = depth_r;

endmodule

[rtl/bracket_balance_checker_top.sv]
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Scans a character stream for unbalanced brackets, tracking quote and
// backslash-escape state, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid/in_ready, in_char_in, in_line_start,  | in
//          | in_line_number                                 |
//  result  | out_valid/out_ready, out_mismatch, out_bad_char,| out
//          | out_expected_char, out_error_line,             |
//          | out_open_depth, out_overflow                   |
//
// One character per cycle unless stalled; result is registered.
// The stack top sits in a register and the RAM read of the entry below it
// is issued each cycle, so consecutive pops run at full rate.
// Reset: synchronous, active low; clears depth, quote and escape state.
// A stalled result holds the output register; input is taken whenever that
// register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bbc_pkg::char_t        in_char_in,
  input  logic                  in_line_start,
  input  logic [15:0]           in_line_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_mismatch,
  output bbc_pkg::char_t        out_bad_char,
  output bbc_pkg::char_t        out_expected_char,
  output logic [15:0]           out_error_line,
  output logic [8:0]            out_open_depth,
  output logic                  out_overflow
);

  import bbc_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic          in_xfer;
  logic          in_double_r, in_double_nxt;
  logic          in_single_r, in_single_nxt;
  logic          esc_odd_r, esc_odd_nxt;
  logic          escaped, dq_toggle, sq_toggle, outside;
  kind_t         ko, kc, top;
  logic          is_open, is_close, match;
  logic          mm, ovf;
  char_t         exp_c;
  stk_op_t       op;
  stk_stat_t     stat;
  logic [DW-1:0] depth, depth_after;
  logic [31:0]   depth_ext;

  logic          out_valid_r;
  logic          mm_r, ovf_r;
  char_t         bad_r, exp_r;
  logic [15:0]   eline_r;
  logic [8:0]    odepth_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign escaped   = in_line_start ? 1'b0 : esc_odd_r;
  assign dq_toggle = (in_char_in == CH_DQUOTE) && !in_single_r && !escaped;
  assign sq_toggle = (in_char_in == CH_SQUOTE) && !in_double_r && !escaped;
  assign outside   = !in_double_r && !in_single_r && !dq_toggle && !sq_toggle;

  assign ko       = opener_kind(in_char_in);
  assign kc       = closer_kind(in_char_in);
  assign is_open  = outside && (ko != KIND_NONE);
  assign is_close = outside && (kc != KIND_NONE);
  assign top      = stat.empty ? KIND_NONE : stat.top_kind;
  assign match    = (top == kc);

  assign mm    = is_close && !match;
  assign ovf   = is_open && stat.full;
  assign exp_c = (top != KIND_NONE) ? closer_char(top) : opener_char(kc);

  assign op.push = in_xfer && is_open && !stat.full;
  assign op.pop  = in_xfer && is_close && match;
  assign op.kind = ko;

  always_comb begin
    in_double_nxt = in_double_r;
    in_single_nxt = in_single_r;
    esc_odd_nxt   = esc_odd_r;
    if (in_xfer) begin
      if (dq_toggle) begin
        in_double_nxt = !in_double_r;
      end else if (sq_toggle) begin
        in_single_nxt = !in_single_r;
      end
      esc_odd_nxt = (in_char_in == CH_BACKSLASH) ? !escaped : 1'b0;
    end
  end

  always_comb begin
    depth_after = depth;
    if (op.push) begin
      depth_after = depth + DW'(1);
    end else if (op.pop) begin
      depth_after = depth - DW'(1);
    end
  end
  assign depth_ext = 32'(depth_after);

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .stat  (stat),
    .depth (depth)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_double_r <= 1'b0;
      in_single_r <= 1'b0;
      esc_odd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_double_r <= in_double_nxt;
      in_single_r <= in_single_nxt;
      esc_odd_r   <= esc_odd_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      mm_r     <= mm;
      ovf_r    <= ovf;
      bad_r    <= mm ? in_char_in : 8'h00;
      exp_r    <= mm ? exp_c : 8'h00;
      eline_r  <= mm ? in_line_number : 16'h0000;
      odepth_r <= depth_ext[8:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mismatch      = mm_r;
  assign out_bad_char      = bad_r;
  assign out_expected_char = exp_r;
  assign out_error_line    = eline_r;
  assign out_open_depth    = odepth_r;
  assign out_overflow      = ovf_r;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth) <= STACK_DEPTH)
    else $error("stack depth above capacity");

  a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
    op.push |=> 32'(depth) == 32'($past(depth)) + 1)
    else $error("push did not advance depth by one");

  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    op.pop |=> 32'(depth) + 1 == 32'($past(depth)))
    else $error("pop did not reduce depth by one");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(mm_r && ovf_r))
    else $error("mismatch and overflow on the same character");
`endif

endmodule
